// ----- rtl/obd_pkg.sv -----
// ----------------------------------------------------------------------------
// obd_pkg
// Types, constants and helpers for the OBD-II reply parser: the prompt
// patterns, token phases, status codes and the character classes.
// ----------------------------------------------------------------------------
package obd_pkg;

	// Number of prompt patterns and the storage depth of each
	localparam int unsigned NUM_PAT   = 4;
	localparam int unsigned PAT_DEPTH = 16;

	// Status codes of a result item
	localparam logic [2:0] STAT_OK        = 3'd0;
	localparam logic [2:0] STAT_STOPPED   = 3'd1;
	localparam logic [2:0] STAT_SEARCHING = 3'd2;
	localparam logic [2:0] STAT_ERROR     = 3'd3;
	localparam logic [2:0] STAT_NO_DATA   = 3'd4;

	// PIDs that update a reading
	localparam logic [7:0] PID_SPEED    = 8'h0D;
	localparam logic [7:0] PID_THROTTLE = 8'h11;

	// Reading value shown until the first update
	localparam logic [9:0] NO_READING = 10'd999;

	// Characters of interest
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;

	// Token parsing phase
	typedef enum logic [1:0] {
		PH_BETWEEN = 2'd0,
		PH_SKIP    = 2'd1,
		PH_DIGITS  = 2'd2,
		PH_DONE    = 2'd3
	} phase_t;

	typedef logic [7:0] pat_row_t [PAT_DEPTH];

	// Prompt patterns in priority order, padded with zeros
	localparam pat_row_t PAT_TEXT [NUM_PAT] = '{
		'{">", "S", "T", "O", "P", "P", "E", "D", 8'h00, 8'h00, 8'h00, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00},
		'{"S", "E", "A", "R", "C", "H", "I", "N", "G", ".", ".", ".",
		  8'h00, 8'h00, 8'h00, 8'h00},
		'{">", "E", "R", "R", "O", "R", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00},
		'{">", "N", "O", " ", "D", "A", "T", "A", 8'h00, 8'h00, 8'h00, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00}
	};

	localparam logic [3:0] PAT_LEN [NUM_PAT] = '{4'd8, 4'd12, 4'd6, 4'd8};

	// Next matched length of pattern m after character c, with p matched.
	// The lead character of every pattern occurs only once in it, so on a
	// mismatch the only possible restart is a fresh lead character.
	function automatic logic [3:0] match_next(input logic [1:0] m,
	                                          input logic [3:0] p,
	                                          input logic [7:0] c);
		logic [3:0] res;
		res = 4'd0;
		if ((p < PAT_LEN[m]) && (c == PAT_TEXT[m][p])) begin
			res = p + 4'd1;
		end else if (c == PAT_TEXT[m][0]) begin
			res = 4'd1;
		end
		return res;
	endfunction

	// Hex digit decode: bit 4 flags a digit, bits 3:0 carry its value
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] res;
		res = 5'd0;
		if (c >= "0" && c <= "9") begin
			res = {1'b1, 4'(c - 8'h30)};
		end else if (c >= "a" && c <= "f") begin
			res = {1'b1, 4'(c - 8'h57)};
		end else if (c >= "A" && c <= "F") begin
			res = {1'b1, 4'(c - 8'h37)};
		end
		return res;
	endfunction

	// Whitespace skipped ahead of a token (space itself splits tokens)
	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) ||
		       (c == CH_FF) || (c == CH_CR);
	endfunction

endpackage

// ----- rtl/obd_response_parser.sv -----
// ----------------------------------------------------------------------------
// obd_response_parser
// Parses an adapter's text reply to a service 01 request one character per
// item and gives status, speed and throttle on the last character.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata                   | tlast        | tuser
//  --------+-----+-------------------------+--------------+------
//  s_*     | in  | [7:0] rx_byte           | last of reply| -
//  m_*     | out | status, speed, throttle | -            | -
//
// One character is taken per cycle, back to back; an item passes the input
// register and is then folded into the reply state. A result is loaded into
// the result register, which drives m_tdata, as its last character is folded in.
// The only stall is a held result: a last character waits in the input
// register until the result register is free.
// Reset clears all reply state and sets both readings to 999.

module obd_response_parser #(
	parameter int unsigned MAX_REPLY = 1023
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tlast,   // last byte of the reply
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // [2:0] status, [12:3] speed,
	                               // [22:13] throttle, [23] zero
);

	localparam int unsigned CNT_W = $clog2(MAX_REPLY + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REPLY);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// reply state
	logic [3:0]        progress_q [obd_pkg::NUM_PAT];
	logic [3:0]        found_q;
	logic [2:0]        tok_index_q;
	obd_pkg::phase_t   tok_phase_q;
	logic [7:0]        tok_value_q;
	logic [7:0]        pid_q;
	logic [7:0]        data_a_q;
	logic              text_ended_q;
	logic [CNT_W-1:0]  byte_count_q;
	logic [9:0]        speed_reg_q;
	logic [9:0]        throttle_reg_q;

	// result register
	logic       out_valid_q;
	logic [2:0] out_status_q;
	logic [9:0] out_speed_q;
	logic [9:0] out_throttle_q;

	// next-state values
	logic [3:0]        progress_nx [obd_pkg::NUM_PAT];
	logic [3:0]        found_nx;
	logic [2:0]        tok_index_nx;
	obd_pkg::phase_t   tok_phase_nx;
	logic [7:0]        tok_value_nx;
	logic [7:0]        pid_nx;
	logic [7:0]        data_a_nx;
	logic              text_ended_nx;
	logic [CNT_W-1:0]  byte_count_nx;
	logic [9:0]        speed_reg_nx;
	logic [9:0]        throttle_reg_nx;
	logic [2:0]        status_nx;

	// scratch
	logic              advance;
	logic              out_load;
	logic              take;
	logic [4:0]        hex;
	obd_pkg::phase_t   ph;
	logic [7:0]        val;
	logic [7:0]        fin_pid;
	logic [7:0]        fin_a;
	logic [14:0]       thr_prod;
	logic [15:0]       thr_y;
	logic [15:0]       thr_q;

	// handshake: the input register moves on unless a last item meets a full
	// result register
	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign out_load = advance && last_s1;
	assign s_tready = !valid_s1 || advance;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_throttle_q, out_speed_q, out_status_q};

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// character decode, token parsing and result forming
	always_comb begin
		for (int m = 0; m < obd_pkg::NUM_PAT; m++) begin
			progress_nx[m] = progress_q[m];
		end
		found_nx        = found_q;
		tok_index_nx    = tok_index_q;
		tok_phase_nx    = tok_phase_q;
		tok_value_nx    = tok_value_q;
		pid_nx          = pid_q;
		data_a_nx       = data_a_q;
		text_ended_nx   = text_ended_q;
		byte_count_nx   = byte_count_q;
		speed_reg_nx    = speed_reg_q;
		throttle_reg_nx = throttle_reg_q;
		status_nx       = obd_pkg::STAT_OK;
		hex             = obd_pkg::hex_decode(byte_s1);
		ph              = tok_phase_q;
		val             = tok_value_q;
		fin_pid         = pid_q;
		fin_a           = data_a_q;

		take = !text_ended_q && (byte_count_q < CNT_MAX);

		if (advance && take) begin
			byte_count_nx = byte_count_q + CNT_W'(1);
			if (byte_s1 == obd_pkg::CH_NUL) begin
				text_ended_nx = 1'b1;
			end else begin
				// prompt matchers, frozen once their pattern is found
				for (int m = 0; m < obd_pkg::NUM_PAT; m++) begin
					if (!found_q[m]) begin
						progress_nx[m] = obd_pkg::match_next(2'(m), progress_q[m], byte_s1);
						if (progress_nx[m] >= obd_pkg::PAT_LEN[m]) begin
							found_nx[m] = 1'b1;
						end
					end
				end
				// tokens
				if (byte_s1 == obd_pkg::CH_SPACE) begin
					if (tok_phase_q != obd_pkg::PH_BETWEEN) begin
						if (tok_index_q == 3'd2) pid_nx = tok_value_q;
						else if (tok_index_q == 3'd3) data_a_nx = tok_value_q;
						if (tok_index_q != 3'd7) tok_index_nx = tok_index_q + 3'd1;
						tok_phase_nx = obd_pkg::PH_BETWEEN;
						tok_value_nx = 8'd0;
					end
				end else begin
					if (ph == obd_pkg::PH_BETWEEN) begin
						ph  = obd_pkg::PH_SKIP;
						val = 8'd0;
					end
					if (ph == obd_pkg::PH_SKIP) begin
						if (!obd_pkg::is_blank(byte_s1)) begin
							ph = hex[4] ? obd_pkg::PH_DIGITS : obd_pkg::PH_DONE;
						end
					end else if (ph == obd_pkg::PH_DIGITS) begin
						if (!hex[4]) ph = obd_pkg::PH_DONE;
					end
					// accumulate, saturating at 255
					if (ph == obd_pkg::PH_DIGITS && hex[4]) begin
						val = (val[7:4] != 4'd0) ? 8'hFF : {val[3:0], hex[3:0]};
					end
					tok_phase_nx = ph;
					tok_value_nx = val;
				end
			end
		end

		// token still open at the end of the reply
		fin_pid = pid_nx;
		fin_a   = data_a_nx;
		if (tok_phase_nx != obd_pkg::PH_BETWEEN) begin
			if (tok_index_nx == 3'd2) fin_pid = tok_value_nx;
			else if (tok_index_nx == 3'd3) fin_a = tok_value_nx;
		end

		// throttle percent: floor(A*100/255), by reciprocal of 255
		thr_prod = 15'(fin_a) * 15'd100;
		thr_y    = 16'(thr_prod) + 16'd1;
		thr_q    = (thr_y + (thr_y >> 8)) >> 8;

		if (out_load) begin
			if (found_nx[0])      status_nx = obd_pkg::STAT_STOPPED;
			else if (found_nx[1]) status_nx = obd_pkg::STAT_SEARCHING;
			else if (found_nx[2]) status_nx = obd_pkg::STAT_ERROR;
			else if (found_nx[3]) status_nx = obd_pkg::STAT_NO_DATA;
			else if (fin_pid == obd_pkg::PID_SPEED) speed_reg_nx = 10'(fin_a);
			else if (fin_pid == obd_pkg::PID_THROTTLE) throttle_reg_nx = 10'(thr_q[6:0]);

			// back to an empty reply
			for (int m = 0; m < obd_pkg::NUM_PAT; m++) begin
				progress_nx[m] = 4'd0;
			end
			found_nx      = 4'd0;
			tok_index_nx  = 3'd0;
			tok_phase_nx  = obd_pkg::PH_BETWEEN;
			tok_value_nx  = 8'd0;
			pid_nx        = 8'd0;
			data_a_nx     = 8'd0;
			text_ended_nx = 1'b0;
			byte_count_nx = '0;
		end
	end

	// reply state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int m = 0; m < obd_pkg::NUM_PAT; m++) begin
				progress_q[m] <= 4'd0;
			end
			found_q        <= 4'd0;
			tok_index_q    <= 3'd0;
			tok_phase_q    <= obd_pkg::PH_BETWEEN;
			tok_value_q    <= 8'd0;
			pid_q          <= 8'd0;
			data_a_q       <= 8'd0;
			text_ended_q   <= 1'b0;
			byte_count_q   <= '0;
			speed_reg_q    <= obd_pkg::NO_READING;
			throttle_reg_q <= obd_pkg::NO_READING;
		end else if (advance) begin
			for (int m = 0; m < obd_pkg::NUM_PAT; m++) begin
				progress_q[m] <= progress_nx[m];
			end
			found_q        <= found_nx;
			tok_index_q    <= tok_index_nx;
			tok_phase_q    <= tok_phase_nx;
			tok_value_q    <= tok_value_nx;
			pid_q          <= pid_nx;
			data_a_q       <= data_a_nx;
			text_ended_q   <= text_ended_nx;
			byte_count_q   <= byte_count_nx;
			speed_reg_q    <= speed_reg_nx;
			throttle_reg_q <= throttle_reg_nx;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q   <= status_nx;
			out_speed_q    <= speed_reg_nx;
			out_throttle_q <= throttle_reg_nx;
		end
	end

	// checks
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		byte_count_q <= CNT_MAX)
		else $error("byte count beyond reply capacity");

	a_ended_counted: assert property (@(posedge clk) disable iff (!arst_n)
		text_ended_q |-> (byte_count_q != '0))
		else $error("text end flagged without a counted byte");

	a_clear_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (byte_count_q == '0 && found_q == 4'd0 && tok_index_q == 3'd0
		              && !text_ended_q))
		else $error("reply state not cleared after a result");

	a_found_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (m_tvalid && out_status_q == $past(status_nx)))
		else $error("result status not the one formed for the reply");

	a_found_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && status_nx != obd_pkg::STAT_OK) |=>
		(speed_reg_q == $past(speed_reg_q) && throttle_reg_q == $past(throttle_reg_q)))
		else $error("reading updated on a prompt reply");

endmodule
